/* design/jaos_pkg.sv */
// Shared types and constants for the JSON array object scanner.
package jaos_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_SIZE      = 2'd2;

   localparam logic [1:0] CSR_BODY_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_OBJECT_LIMIT = 2'd1;
   localparam logic [1:0] CSR_COUNT_LIMIT  = 2'd2;

   localparam logic [24:0] BODY_LIMIT_RESET   = 25'd8388608;
   localparam logic [15:0] OBJECT_LIMIT_RESET = 16'd4096;
   localparam logic [15:0] COUNT_LIMIT_RESET  = 16'd8192;

   localparam logic        CMD_FEED   = 1'b0;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_KEY_A  = 8'h61;
   localparam logic [7:0] CH_KEY_C  = 8'h63;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [24:0] body;
      logic [15:0] object;
      logic [15:0] count;
   } limits_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  object_byte;
      logic        object_byte_valid;
      logic        object_end;
      logic [15:0] object_total;
      logic [24:0] body_total;
      logic        stream_done;
   } rsp_type;

endpackage

/* design/jaos_scan.sv */
// Scan state registers, closer stack and the per-item next-state logic.
module jaos_scan #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                cmd,
   input  logic [7:0]          in_byte,
   input  jaos_pkg::limits_type limits,
   output jaos_pkg::rsp_type   rsp
);

   localparam int DepthWidth = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic [1:0]            err;
      logic [24:0]           body_count;
      logic [15:0]           object_count;
      logic [15:0]           member_length;
      logic [DepthWidth-1:0] depth;
      logic                  at_key;
      logic [7:0]            key_first;
      logic [7:0]            key_second;
      logic [1:0]            key_count;
      logic                  root_open;
      logic                  root_done;
      logic                  in_str;
      logic                  escape;
      logic                  key_cap;
      logic                  key_esc;
      logic                  want_colon;
      logic                  ac_pending;
      logic                  want_ac;
      logic                  ac_seen;
      logic                  in_ac;
      logic                  ac_done;
      logic                  want_obj;
      logic                  any_obj;
      logic                  capture;
   } scan_state_type;

   typedef struct packed {
      scan_state_type st;
      logic [1:0]     code;
      logic           cap;
      logic           closed;
      logic           push;
      logic           pop;
      logic           push_bit;
   } scan_out_type;

   localparam logic [DepthWidth-1:0] DEPTH_ZERO = '0;
   localparam logic [DepthWidth-1:0] DEPTH_ONE  = DepthWidth'(1);
   localparam logic [DepthWidth-1:0] DEPTH_TWO  = DepthWidth'(2);
   localparam logic [DepthWidth-1:0] DEPTH_FULL = DepthWidth'(STACK_DEPTH);

   function automatic scan_out_type scan_one(input scan_state_type s, input logic top_brace,
                                             input logic [7:0] c,
                                             input jaos_pkg::limits_type lim);
      scan_out_type r;
      logic         blank;
      logic         over;
      r          = '0;
      r.st       = s;
      r.code     = jaos_pkg::ST_OK;
      blank = (c == jaos_pkg::CH_SPACE) || (c == jaos_pkg::CH_TAB) ||
              (c == jaos_pkg::CH_CR) || (c == jaos_pkg::CH_LF);
      if (r.st.root_done) begin
         r.code = blank ? jaos_pkg::ST_OK : jaos_pkg::ST_MALFORMED;
         return r;
      end
      if (r.st.capture) begin
         if (r.st.member_length >= lim.object) begin
            r.code = jaos_pkg::ST_SIZE;
            return r;
         end
         r.st.member_length = r.st.member_length + 16'd1;
         r.cap = 1'b1;
      end
      if (r.st.in_str) begin
         if (r.st.escape) begin
            r.st.escape = 1'b0;
            if (r.st.key_cap) begin
               r.st.key_esc = 1'b1;
            end
         end else if (c == jaos_pkg::CH_BSLASH) begin
            r.st.escape = 1'b1;
         end else if (c == jaos_pkg::CH_QUOTE) begin
            r.st.in_str = 1'b0;
            if (r.st.key_cap) begin
               r.st.ac_pending = !r.st.key_esc && (r.st.key_count == 2'd2) &&
                                 (r.st.key_first == jaos_pkg::CH_KEY_A) &&
                                 (r.st.key_second == jaos_pkg::CH_KEY_C);
               r.st.want_colon = 1'b1;
               r.st.key_cap    = 1'b0;
            end
            if (r.st.depth == DEPTH_ONE) begin
               r.st.at_key = 1'b0;
            end
         end else if (c < jaos_pkg::CTRL_LIMIT) begin
            r.code = jaos_pkg::ST_MALFORMED;
         end else if (r.st.key_cap) begin
            if (r.st.key_count == 2'd0) begin
               r.st.key_first = c;
            end else if (r.st.key_count == 2'd1) begin
               r.st.key_second = c;
            end
            if (r.st.key_count < 2'd3) begin
               r.st.key_count = r.st.key_count + 2'd1;
            end
         end
         return r;
      end
      if (blank) begin
         return r;
      end
      if (!r.st.root_open) begin
         if (c != jaos_pkg::CH_LBRACE) begin
            r.code = jaos_pkg::ST_MALFORMED;
            return r;
         end
         r.st.root_open = 1'b1;
      end
      if (r.st.want_colon) begin
         if (c != jaos_pkg::CH_COLON) begin
            r.code = jaos_pkg::ST_MALFORMED;
            return r;
         end
         r.st.want_colon = 1'b0;
         r.st.want_ac    = r.st.ac_pending;
         r.st.ac_pending = 1'b0;
         r.st.at_key     = 1'b0;
         return r;
      end
      if (r.st.want_ac) begin
         if (c != jaos_pkg::CH_LBRACK || r.st.ac_seen || r.st.depth != DEPTH_ONE) begin
            r.code = jaos_pkg::ST_MALFORMED;
            return r;
         end
         r.st.ac_seen  = 1'b1;
         r.st.in_ac    = 1'b1;
         r.st.want_obj = 1'b1;
         r.st.any_obj  = 1'b0;
         r.st.want_ac  = 1'b0;
      end
      if (c == jaos_pkg::CH_QUOTE) begin
         r.st.in_str    = 1'b1;
         r.st.escape    = 1'b0;
         r.st.key_esc   = 1'b0;
         r.st.key_count = 2'd0;
         r.st.key_cap   = (r.st.depth == DEPTH_ONE) && r.st.at_key;
         return r;
      end
      if (r.st.in_ac && r.st.depth == DEPTH_TWO) begin
         if (c == jaos_pkg::CH_LBRACE) begin
            if (!r.st.want_obj) begin
               r.code = jaos_pkg::ST_MALFORMED;
               return r;
            end
            r.st.want_obj = 1'b0;
         end else if (c == jaos_pkg::CH_COMMA) begin
            if (r.st.want_obj || !r.st.any_obj) begin
               r.code = jaos_pkg::ST_MALFORMED;
               return r;
            end
            r.st.want_obj = 1'b1;
         end else if (c == jaos_pkg::CH_RBRACK) begin
            if (r.st.want_obj && r.st.any_obj) begin
               r.code = jaos_pkg::ST_MALFORMED;
               return r;
            end
         end else begin
            r.code = jaos_pkg::ST_MALFORMED;
            return r;
         end
      end
      if (c == jaos_pkg::CH_LBRACE || c == jaos_pkg::CH_LBRACK) begin
         if (r.st.depth >= DEPTH_FULL) begin
            r.code = jaos_pkg::ST_SIZE;
            return r;
         end
         if (r.st.in_ac && r.st.depth == DEPTH_TWO && c == jaos_pkg::CH_LBRACE) begin
            r.st.capture       = 1'b1;
            r.st.member_length = 16'd1;
            r.cap              = 1'b1;
         end
         r.push     = 1'b1;
         r.push_bit = (c == jaos_pkg::CH_LBRACE);
         r.st.depth = r.st.depth + DEPTH_ONE;
      end else if (c == jaos_pkg::CH_RBRACE || c == jaos_pkg::CH_RBRACK) begin
         if (r.st.depth == DEPTH_ZERO || top_brace != (c == jaos_pkg::CH_RBRACE)) begin
            r.code = jaos_pkg::ST_MALFORMED;
            return r;
         end
         if (c == jaos_pkg::CH_RBRACK && r.st.in_ac && r.st.depth == DEPTH_TWO) begin
            r.st.in_ac   = 1'b0;
            r.st.ac_done = 1'b1;
         end
         r.pop      = 1'b1;
         r.st.depth = r.st.depth - DEPTH_ONE;
         if (r.st.capture && r.st.depth == DEPTH_TWO && c == jaos_pkg::CH_RBRACE) begin
            over = r.st.object_count >= lim.count;
            r.st.capture = 1'b0;
            r.st.any_obj = 1'b1;
            if (r.st.object_count != jaos_pkg::COUNT_MAX) begin
               r.st.object_count = r.st.object_count + 16'd1;
            end
            if (over) begin
               r.code = jaos_pkg::ST_SIZE;
               return r;
            end
            r.closed = 1'b1;
         end
         if (r.st.depth == DEPTH_ZERO) begin
            if (c != jaos_pkg::CH_RBRACE) begin
               r.code = jaos_pkg::ST_MALFORMED;
               return r;
            end
            r.st.root_done = 1'b1;
         end
      end
      if (r.st.depth == DEPTH_ONE) begin
         r.st.at_key = (c == jaos_pkg::CH_LBRACE) || (c == jaos_pkg::CH_COMMA);
      end
      return r;
   endfunction

   scan_state_type         state_ff;
   scan_state_type         state_in;
   logic [STACK_DEPTH-1:0] stack_ff;
   logic [STACK_DEPTH-1:0] stack_in;
   scan_out_type           so;
   logic                   incomplete;
   logic [1:0]             status;

   always_comb begin
      state_in = state_ff;
      stack_in = stack_ff;
      so = scan_one(state_ff, stack_ff[0], in_byte, limits);
      incomplete = !state_ff.root_done || state_ff.in_str || state_ff.depth != DEPTH_ZERO ||
                   !state_ff.ac_seen || !state_ff.ac_done || state_ff.capture ||
                   state_ff.want_colon || state_ff.want_ac;
      if (cmd == jaos_pkg::CMD_FEED) begin
         if (state_ff.err == jaos_pkg::ST_OK) begin
            if (state_ff.body_count >= limits.body) begin
               state_in.err = jaos_pkg::ST_SIZE;
            end else begin
               state_in            = so.st;
               state_in.body_count = state_ff.body_count + 25'd1;
               state_in.err        = so.code;
               if (so.push) begin
                  stack_in = {stack_ff[STACK_DEPTH-2:0], so.push_bit};
               end else if (so.pop) begin
                  stack_in = {1'b0, stack_ff[STACK_DEPTH-1:1]};
               end
            end
         end
         status = state_in.err;
      end else if (state_ff.err != jaos_pkg::ST_OK) begin
         status = state_ff.err;
      end else begin
         status = incomplete ? jaos_pkg::ST_MALFORMED : jaos_pkg::ST_OK;
      end
      rsp.status            = status;
      rsp.object_byte       = (cmd == jaos_pkg::CMD_FEED) ? in_byte : 8'd0;
      rsp.object_byte_valid = (cmd == jaos_pkg::CMD_FEED) && state_ff.err == jaos_pkg::ST_OK &&
                              state_ff.body_count < limits.body && so.cap &&
                              status == jaos_pkg::ST_OK;
      rsp.object_end        = (cmd == jaos_pkg::CMD_FEED) && state_ff.err == jaos_pkg::ST_OK &&
                              state_ff.body_count < limits.body && so.closed &&
                              status == jaos_pkg::ST_OK;
      rsp.object_total      = state_in.object_count;
      rsp.body_total        = state_in.body_count;
      rsp.stream_done       = (cmd != jaos_pkg::CMD_FEED) && state_ff.err == jaos_pkg::ST_OK &&
                              !incomplete;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stack_ff <= stack_in;
      end
   end

endmodule

/* design/json_array_object_scanner_core.sv */
// Scans a JSON response body one byte per item, yielding the "ac" array member objects.
// Each item sits in the input register; the scan logic updates the scan state and
// writes the result register in the same cycle, so a new item is taken every cycle
// while rsp_ready is high. The closer stack is a STACK_DEPTH-bit shift register whose
// top bit is read in place, so nesting never stalls the scan. Limit registers take
// effect on the next item and are written through csr_wr_en, csr_index and csr_wdata.
module json_array_object_scanner_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_object_byte,
   output logic        rsp_object_byte_valid,
   output logic        rsp_object_end,
   output logic [15:0] rsp_object_total,
   output logic [24:0] rsp_body_total,
   output logic        rsp_stream_done,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_wdata
);

   jaos_pkg::limits_type limits_ff;
   logic                 in_valid_ff;
   logic                 in_cmd_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   jaos_pkg::rsp_type    out_ff;
   jaos_pkg::rsp_type    rsp_in;
   logic                 advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   jaos_scan #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cmd     (in_cmd_ff),
      .in_byte (in_byte_ff),
      .limits  (limits_ff),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.body   <= jaos_pkg::BODY_LIMIT_RESET;
         limits_ff.object <= jaos_pkg::OBJECT_LIMIT_RESET;
         limits_ff.count  <= jaos_pkg::COUNT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            jaos_pkg::CSR_BODY_LIMIT:   limits_ff.body   <= csr_wdata;
            jaos_pkg::CSR_OBJECT_LIMIT: limits_ff.object <= csr_wdata[15:0];
            jaos_pkg::CSR_COUNT_LIMIT:  limits_ff.count  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_ff.status;
   assign rsp_object_byte       = out_ff.object_byte;
   assign rsp_object_byte_valid = out_ff.object_byte_valid;
   assign rsp_object_end        = out_ff.object_end;
   assign rsp_object_total      = out_ff.object_total;
   assign rsp_body_total        = out_ff.body_total;
   assign rsp_stream_done       = out_ff.stream_done;

endmodule
